// File: hdl/fasta_stream_parser_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the FASTA stream parser unit.
// Each macro places one labelled concurrent assertion on the rising clock
// edge, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef FASTA_STREAM_PARSER_UNIT_ASSERT_SVH
`define FASTA_STREAM_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/fsp_pkg.sv
// ---------------------------------------------------------------------------
// FASTA stream parser package
// Shared constants, codes and types of the FASTA stream parser unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

   // Width of the ignored and warning counters.
   localparam int COUNT_WIDTH = 32;

   // Characters with a special meaning in the text.
   localparam logic [7:0] CHAR_MARKER  = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_COMMENT = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // '\n'
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   // Configuration register indexes.
   localparam logic [2:0] REG_MODE_MAP_0    = 3'd0;
   localparam logic [2:0] REG_MODE_MAP_1    = 3'd1;
   localparam logic [2:0] REG_MODE_MAP_2    = 3'd2;
   localparam logic [2:0] REG_MODE_MAP_3    = 3'd3;
   localparam logic [2:0] REG_HIGH_MODE     = 3'd4;
   localparam logic [2:0] REG_CLEAR_COUNTS  = 3'd5;
   localparam logic [2:0] REG_CAPTURE_CMT   = 3'd6;

   // Character modes.
   localparam logic [1:0] MODE_IGNORE = 2'd1;
   localparam logic [1:0] MODE_WARN   = 2'd2;

   // Kind of a result word.
   typedef enum logic [2:0] {
      KIND_ID         = 3'd0,
      KIND_COMMENT    = 3'd1,
      KIND_SEQUENCE   = 3'd2,
      KIND_RECORD_END = 3'd3,
      KIND_STREAM_END = 3'd4,
      KIND_ERROR      = 3'd5
   } kind_type;

   // Parser states, one-hot.
   typedef enum logic [5:0] {
      ST_MARKER    = 6'b000001,
      ST_HEADER    = 6'b000010,
      ST_CMT_CHECK = 6'b000100,
      ST_CMT_BODY  = 6'b001000,
      ST_SEQ_START = 6'b010000,
      ST_SEQ_MID   = 6'b100000
   } parse_state_type;

endpackage

`default_nettype wire

// File: hdl/fasta_stream_parser_unit.sv
// ---------------------------------------------------------------------------
// FASTA stream parser unit
// Labels the bytes of a FASTA text stream as ID, comment or sequence bytes,
// filters sequence characters through a per-character mode map and reports
// record ends, stream ends and format errors.
// ---------------------------------------------------------------------------
//   Channel   Direction  Ports        Contents
//   req       in         req_t*       one text byte, tlast marks stream end
//   rsp       out        rsp_t*       kind in tuser, byte/flag/counts in tdata
//   csr       in/out     csr_p*       APB register port, 64-bit data
//
// One byte is taken per cycle unless a stalled result holds the input register. A byte
// waits in the input register and its result, if any, is then registered in the result
// register; the per-byte state update is a single pass of logic on the input register.
// Reset is synchronous and active high; it restores all registers but the data fields.
// A stalled result holds the result register; the input register is still
// free to take a byte whenever the result register can take its outcome.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fasta_stream_parser_unit
   import fsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // in_end
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [7:0] out_byte, [8] out_warned,
                                         // [40:9] out_ignored,
                                         // [72:41] out_warnings, [79:73] zero
   output logic [2:0]       rsp_tuser,   // [2:0] out_kind
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers
   logic [63:0] map0_ff, map1_ff, map2_ff, map3_ff;
   logic [1:0]  high_mode_ff;
   logic        clear_counts_ff;
   logic        capture_ff;

   // Input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;

   // Parser state
   parse_state_type        state_ff, state_in;
   logic                   comment_seen_ff, comment_seen_in;
   logic                   record_open_ff, record_open_in;
   logic [COUNT_WIDTH-1:0] ignored_ff, ignored_in;
   logic [COUNT_WIDTH-1:0] warnings_ff, warnings_in;

   // Result register
   logic        rsp_valid_ff;
   kind_type    out_kind_ff;
   logic [7:0]  out_byte_ff;
   logic        out_warned_ff;
   logic [31:0] out_ignored_ff;
   logic [31:0] out_warnings_ff;

   // Result of the current byte
   logic        emit;
   kind_type    emit_kind;
   logic [7:0]  emit_byte;
   logic        emit_warned;

   logic        out_free;
   logic        proc;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Sequence character handling
   logic        do_seq;
   logic [7:0]  up_byte;
   logic        up_is_space;
   logic [63:0] map_sel;
   logic [1:0]  up_mode;

   // Handshakes: the input register drains whenever the result register is free.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[5:3];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map0_ff         <= '0;
         map1_ff         <= '0;
         map2_ff         <= '0;
         map3_ff         <= '0;
         high_mode_ff    <= '0;
         clear_counts_ff <= 1'b0;
         capture_ff      <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE_MAP_0:   map0_ff         <= csr_pwdata;
            REG_MODE_MAP_1:   map1_ff         <= csr_pwdata;
            REG_MODE_MAP_2:   map2_ff         <= csr_pwdata;
            REG_MODE_MAP_3:   map3_ff         <= csr_pwdata;
            REG_HIGH_MODE:    high_mode_ff    <= csr_pwdata[1:0];
            REG_CLEAR_COUNTS: clear_counts_ff <= csr_pwdata[0];
            REG_CAPTURE_CMT:  capture_ff      <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         REG_MODE_MAP_0:   csr_prdata = map0_ff;
         REG_MODE_MAP_1:   csr_prdata = map1_ff;
         REG_MODE_MAP_2:   csr_prdata = map2_ff;
         REG_MODE_MAP_3:   csr_prdata = map3_ff;
         REG_HIGH_MODE:    csr_prdata = {62'd0, high_mode_ff};
         REG_CLEAR_COUNTS: csr_prdata = {63'd0, clear_counts_ff};
         REG_CAPTURE_CMT:  csr_prdata = {63'd0, capture_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   // Uppercasing, whitespace test and mode lookup of a sequence character.
   always_comb begin
      up_byte = in_byte_ff;
      if (in_byte_ff >= CHAR_LOWER_A && in_byte_ff <= CHAR_LOWER_Z) begin
         up_byte = {in_byte_ff[7:6], 1'b0, in_byte_ff[4:0]};
      end
      up_is_space = (up_byte == CHAR_SPACE) ||
                    (up_byte >= CHAR_TAB && up_byte <= CHAR_CR);
      unique case (up_byte[6:5])
         2'd0:    map_sel = map0_ff;
         2'd1:    map_sel = map1_ff;
         2'd2:    map_sel = map2_ff;
         default: map_sel = map3_ff;
      endcase
      if (up_byte[7]) begin
         up_mode = high_mode_ff;
      end else begin
         up_mode = map_sel[{up_byte[4:0], 1'b0} +: 2];
      end
   end

   // Next state and result of the byte in the input register.
   always_comb begin
      state_in        = state_ff;
      comment_seen_in = comment_seen_ff;
      record_open_in  = record_open_ff;
      ignored_in      = ignored_ff;
      warnings_in     = warnings_ff;
      emit            = 1'b0;
      emit_kind       = KIND_ID;
      emit_byte       = 8'd0;
      emit_warned     = 1'b0;
      do_seq          = 1'b0;

      if (in_end_ff) begin
         // End of stream closes an open record; only between records does it report stream end.
         emit = 1'b1;
         if (state_ff != ST_MARKER || record_open_ff) begin
            state_in        = ST_MARKER;
            record_open_in  = 1'b0;
            comment_seen_in = 1'b0;
            emit_kind       = KIND_RECORD_END;
         end else begin
            emit_kind = KIND_STREAM_END;
         end
      end else begin
         unique case (state_ff)
            ST_MARKER: begin
               if (in_byte_ff == CHAR_MARKER) begin
                  state_in        = ST_HEADER;
                  record_open_in  = 1'b1;
                  comment_seen_in = 1'b0;
                  if (clear_counts_ff) begin
                     ignored_in  = '0;
                     warnings_in = '0;
                  end
               end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_ERROR;
               end
            end
            ST_HEADER: begin
               if (in_byte_ff == CHAR_NEWLINE) begin
                  state_in = ST_CMT_CHECK;
               end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_ID;
                  emit_byte = in_byte_ff;
               end
            end
            ST_CMT_CHECK: begin
               if (in_byte_ff == CHAR_COMMENT) begin
                  // A newline separates this comment line from an earlier one.
                  comment_seen_in = 1'b1;
                  state_in        = ST_CMT_BODY;
                  if (capture_ff && comment_seen_ff) begin
                     emit      = 1'b1;
                     emit_kind = KIND_COMMENT;
                     emit_byte = CHAR_NEWLINE;
                  end
               end else if (in_byte_ff == CHAR_MARKER) begin
                  state_in        = ST_HEADER;
                  record_open_in  = 1'b1;
                  comment_seen_in = 1'b0;
                  if (clear_counts_ff) begin
                     ignored_in  = '0;
                     warnings_in = '0;
                  end
                  emit      = 1'b1;
                  emit_kind = KIND_RECORD_END;
               end else begin
                  do_seq = 1'b1;
               end
            end
            ST_CMT_BODY: begin
               if (in_byte_ff == CHAR_NEWLINE) begin
                  state_in = ST_CMT_CHECK;
               end else if (capture_ff) begin
                  emit      = 1'b1;
                  emit_kind = KIND_COMMENT;
                  emit_byte = in_byte_ff;
               end
            end
            ST_SEQ_START: begin
               if (in_byte_ff == CHAR_MARKER) begin
                  state_in        = ST_HEADER;
                  record_open_in  = 1'b1;
                  comment_seen_in = 1'b0;
                  if (clear_counts_ff) begin
                     ignored_in  = '0;
                     warnings_in = '0;
                  end
                  emit      = 1'b1;
                  emit_kind = KIND_RECORD_END;
               end else begin
                  do_seq = 1'b1;
               end
            end
            ST_SEQ_MID: begin
               do_seq = 1'b1;
            end
            default: begin
               state_in       = ST_MARKER;
               record_open_in = 1'b0;
            end
         endcase

         // Sequence characters: newline, whitespace, then the mode map.
         if (do_seq) begin
            if (up_byte == CHAR_NEWLINE) begin
               state_in = ST_SEQ_START;
            end else begin
               state_in = ST_SEQ_MID;
               if (!up_is_space) begin
                  if (up_mode == MODE_IGNORE) begin
                     if (ignored_ff != '1) begin
                        ignored_in = ignored_ff + 1'b1;
                     end
                  end else begin
                     emit      = 1'b1;
                     emit_kind = KIND_SEQUENCE;
                     emit_byte = up_byte;
                     if (up_mode == MODE_WARN) begin
                        emit_warned = 1'b1;
                        if (warnings_ff != '1) begin
                           warnings_in = warnings_ff + 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_MARKER;
         comment_seen_ff <= 1'b0;
         record_open_ff  <= 1'b0;
         ignored_ff      <= '0;
         warnings_ff     <= '0;
      end else if (proc) begin
         state_ff        <= state_in;
         comment_seen_ff <= comment_seen_in;
         record_open_ff  <= record_open_in;
         ignored_ff      <= ignored_in;
         warnings_ff     <= warnings_in;
      end
   end

   // Result register; the counts shown are those after this byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= proc && emit;
      end
      if (proc && emit) begin
         out_kind_ff     <= emit_kind;
         out_byte_ff     <= emit_byte;
         out_warned_ff   <= emit_warned;
         out_ignored_ff  <= 32'(ignored_in);
         out_warnings_ff <= 32'(warnings_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {7'd0, out_warnings_ff, out_ignored_ff, out_warned_ff, out_byte_ff};

   // Checks
   `include "fasta_stream_parser_unit_assert.svh"

   `FSP_ASSERT_SAME(a_warned_is_sequence,
      rsp_tvalid && rsp_tdata[8],
      rsp_tuser == KIND_SEQUENCE,
      "warn flag on a result that is not a sequence byte")
   `FSP_ASSERT_SAME(a_byte_zero_on_events,
      rsp_tvalid && (rsp_tuser == KIND_RECORD_END || rsp_tuser == KIND_STREAM_END ||
                     rsp_tuser == KIND_ERROR),
      rsp_tdata[7:0] == 8'd0,
      "event result carries a byte")
   `FSP_ASSERT_NEXT(a_end_closes_record,
      proc && in_end_ff,
      state_ff == ST_MARKER && !record_open_ff,
      "end of stream left a record open")
   `FSP_ASSERT_NEXT(a_stream_end_between,
      proc && in_end_ff && state_ff == ST_MARKER && !record_open_ff,
      rsp_tvalid && rsp_tuser == KIND_STREAM_END,
      "end between records did not report stream end")

endmodule

`default_nettype wire

// File: dv/fasta_stream_parser_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FASTA stream parser unit testbench
// Streams FASTA text into the parser one byte per word and keeps its own
// model of the labelling rules: record, header, comment and sequence
// states, the per-character mode map and the running counts. Every result
// word is compared field by field with the oldest predicted label. The
// stimulus opens with directed corner cases and then runs randomised
// records under several register settings, with bursty input, a stalling
// result side and one long hold-off that backs up the whole pipeline.
// ---------------------------------------------------------------------------

module fasta_stream_parser_unit_tb;
   import fsp_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;

   // Ways in which the result side stalls.
   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;

   // One predicted result word.
   typedef struct {
      kind_type    kind;
      logic [7:0]  value;
      logic        warned;
      logic [31:0] ignored;
      logic [31:0] warnings;
   } label_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] in_byte
   logic        req_tlast = 1'b0;     // in_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;            // [7:0] out_byte, [8] out_warned,
                                      // [40:9] out_ignored,
                                      // [72:41] out_warnings, [79:73] zero
   logic [2:0]  rsp_tuser;            // [2:0] out_kind
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // Model copy of the registers, starting at their reset values.
   logic [63:0] mode_map [4] = '{default: '0};
   logic [1:0]  high_mode = 2'd0;
   logic        clear_per_record = 1'b0;
   logic        capture_comments = 1'b1;

   // Model copy of the parser state.
   parse_state_type        parse_st = ST_MARKER;
   logic                   comment_seen = 1'b0;
   logic                   record_open = 1'b0;
   logic [COUNT_WIDTH-1:0] ignored_count = '0;
   logic [COUNT_WIDTH-1:0] warning_count = '0;

   label_type pending_labels [$];
   int     mismatches = 0;
   int     words_sent = 0;
   int     burst_left = 0;
   int     stall_style = STALL_NONE;
   bit     hold_pending = 1'b0;

   fasta_stream_parser_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Label prediction
   // ------------------------------------------------------------------

   task automatic push_label(input kind_type kind, input logic [7:0] value,
                             input logic warned);
      label_type l;
      l.kind     = kind;
      l.value    = value;
      l.warned   = warned;
      l.ignored  = ignored_count[31:0];
      l.warnings = warning_count[31:0];
      pending_labels.push_back(l);
   endtask

   // Mode of a character: one map covers 32 codes, two bits per code.
   function automatic logic [1:0] char_mode(input logic [7:0] c);
      logic [63:0] map_word;
      if (c[7]) return high_mode;
      map_word = mode_map[c[6:5]];
      return map_word[2 * c[4:0] +: 2];
   endfunction

   task automatic start_record();
      if (clear_per_record) begin
         ignored_count = '0;
         warning_count = '0;
      end
      record_open  = 1'b1;
      comment_seen = 1'b0;
      parse_st     = ST_HEADER;
   endtask

   // The counts cannot reach saturation within a run of this length, but
   // the model still holds them at all ones.
   task automatic label_sequence_char(input logic [7:0] raw);
      logic [7:0] c;
      logic [1:0] mode;
      c = raw;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) c[5] = 1'b0;
      if (c == CHAR_NEWLINE) begin
         parse_st = ST_SEQ_START;
         return;
      end
      parse_st = ST_SEQ_MID;
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
      mode = char_mode(c);
      if (mode == MODE_IGNORE) begin
         if (ignored_count != '1) ignored_count++;
      end else if (mode == MODE_WARN) begin
         if (warning_count != '1) warning_count++;
         push_label(KIND_SEQUENCE, c, 1'b1);
      end else begin
         push_label(KIND_SEQUENCE, c, 1'b0);
      end
   endtask

   // Works out the label, if any, that one accepted input word produces.
   task automatic label_byte(input logic [7:0] text_byte, input logic stream_end);
      if (stream_end) begin
         if (parse_st != ST_MARKER || record_open) begin
            parse_st     = ST_MARKER;
            record_open  = 1'b0;
            comment_seen = 1'b0;
            push_label(KIND_RECORD_END, 8'h00, 1'b0);
         end else begin
            push_label(KIND_STREAM_END, 8'h00, 1'b0);
         end
         return;
      end
      case (parse_st)
         ST_MARKER: begin
            if (text_byte == CHAR_MARKER) start_record();
            else push_label(KIND_ERROR, 8'h00, 1'b0);
         end
         ST_HEADER: begin
            if (text_byte == CHAR_NEWLINE) parse_st = ST_CMT_CHECK;
            else push_label(KIND_ID, text_byte, 1'b0);
         end
         ST_CMT_CHECK: begin
            if (text_byte == CHAR_COMMENT) begin
               // Comment lines after the first are separated by a newline.
               if (capture_comments && comment_seen)
                  push_label(KIND_COMMENT, CHAR_NEWLINE, 1'b0);
               comment_seen = 1'b1;
               parse_st     = ST_CMT_BODY;
            end else if (text_byte == CHAR_MARKER) begin
               start_record();
               push_label(KIND_RECORD_END, 8'h00, 1'b0);
            end else begin
               label_sequence_char(text_byte);
            end
         end
         ST_CMT_BODY: begin
            if (text_byte == CHAR_NEWLINE) parse_st = ST_CMT_CHECK;
            else if (capture_comments) push_label(KIND_COMMENT, text_byte, 1'b0);
         end
         ST_SEQ_START: begin
            if (text_byte == CHAR_MARKER) begin
               start_record();
               push_label(KIND_RECORD_END, 8'h00, 1'b0);
            end else begin
               label_sequence_char(text_byte);
            end
         end
         default: label_sequence_char(text_byte);
      endcase
   endtask

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string field_name,
                                       input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %h, got %h",
                  $time, field_name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      label_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_labels.size() == 0) begin
            $display("%0t: unexpected result word: expected none, got kind %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_labels.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("byte", want.value, rsp_tdata[7:0]);
            check_field("warned", want.warned, rsp_tdata[8]);
            check_field("ignored count", want.ignored, rsp_tdata[40:9]);
            check_field("warning count", want.warnings, rsp_tdata[72:41]);
            check_field("padding", 32'd0, rsp_tdata[79:73]);
         end
      end
   end

   // The result side stalls in its own pattern; a requested hold-off keeps
   // it stalled for a long stretch so that the parser backs up.
   initial begin : result_stall
      int hold_left;
      int cycle_count;
      hold_left   = 0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_style)
               STALL_NONE:   rsp_tready <= 1'b1;
               STALL_RANDOM: rsp_tready <= ($urandom_range(0, 2) != 0);
               default:      rsp_tready <= ((cycle_count % 11) < 7);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Sends one word in bursts of random length with random gaps between.
   task automatic send_word(input logic [7:0] text_byte, input logic stream_end);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= text_byte;
      req_tlast  <= stream_end;
      do @(posedge clock); while (!req_tready);
      label_byte(text_byte, stream_end);
      words_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_word(text[i], 1'b0);
   endtask

   // Stops sending and waits for every predicted word, then lets words that
   // produce no result settle.
   task automatic wait_for_idle();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_labels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_labels.size() != 0) begin
         $display("%0t: %0d expected result words never arrived",
                  $time, pending_labels.size());
         mismatches++;
         pending_labels.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_MODE_MAP_0, REG_MODE_MAP_1,
         REG_MODE_MAP_2, REG_MODE_MAP_3: mode_map[index[1:0]] = value;
         REG_HIGH_MODE:    high_mode = value[1:0];
         REG_CLEAR_COUNTS: clear_per_record = value[0];
         REG_CAPTURE_CMT:  capture_comments = value[0];
         default: ;
      endcase
   endtask

   task automatic write_all_settings(input logic [63:0] map0, map1, map2, map3,
                                     input logic [1:0] high,
                                     input logic clear, capture);
      wait_for_idle();
      write_reg(REG_MODE_MAP_0, map0);
      write_reg(REG_MODE_MAP_1, map1);
      write_reg(REG_MODE_MAP_2, map2);
      write_reg(REG_MODE_MAP_3, map3);
      write_reg(REG_HIGH_MODE, 64'(high));
      write_reg(REG_CLEAR_COUNTS, 64'(clear));
      write_reg(REG_CAPTURE_CMT, 64'(capture));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_line_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
      return c;
   endfunction

   // Mostly bases and letters in either case, with whitespace, mid-line
   // markers and arbitrary bytes mixed in.
   function automatic logic [7:0] pick_sequence_char();
      string      bases = "ACGTNacgtnRYKM";
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = bases[$urandom_range(0, bases.len() - 1)];
         4, 5: begin
            c    = 8'("A" + $urandom_range(0, 25));
            c[5] = ($urandom_range(0, 1) != 0);
         end
         6: c = ($urandom_range(0, 1) != 0) ? CHAR_SPACE
                                            : 8'($urandom_range(CHAR_TAB, CHAR_CR));
         7: c = CHAR_MARKER;
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // A well-formed record with random content; now and then a
   // sequence line lacks its newline.
   task automatic send_record();
      int id_len, comment_lines, seq_lines, line_len;
      send_word(CHAR_MARKER, 1'b0);
      id_len = $urandom_range(0, 8);
      repeat (id_len) send_word(pick_line_byte(), 1'b0);
      send_word(CHAR_NEWLINE, 1'b0);
      comment_lines = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (comment_lines) begin
         send_word(CHAR_COMMENT, 1'b0);
         line_len = $urandom_range(0, 6);
         repeat (line_len) send_word(pick_line_byte(), 1'b0);
         send_word(CHAR_NEWLINE, 1'b0);
      end
      seq_lines = $urandom_range(0, 4);
      repeat (seq_lines) begin
         line_len = $urandom_range(0, 14);
         repeat (line_len) send_word(pick_sequence_char(), 1'b0);
         if ($urandom_range(0, 11) != 0) send_word(CHAR_NEWLINE, 1'b0);
      end
   endtask

   // Records interleaved with stream ends and, at the given percentage,
   // short runs of arbitrary bytes and end markers.
   task automatic send_stream(input int target, input int noise_pct);
      int stop_at;
      stop_at = words_sent + target;
      while (words_sent < stop_at) begin
         if ($urandom_range(1, 100) <= noise_pct) begin
            repeat ($urandom_range(1, 4))
               send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
         end else if ($urandom_range(0, 19) == 0) begin
            send_word(8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 1) != 0) send_word(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            send_record();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corner cases under the reset settings: all characters accepted,
   // comments captured.
   task automatic test_directed_cases();
      stall_style = STALL_RANDOM;
      // Bad record start, at both ends of the byte range.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      // End of stream between records.
      send_word(8'hA5, 1'b1);
      // Header, then a comment line followed by two empty ones.
      send_text(">I\n;c\n;\n;\n");
      // Lowercase, a dropped space, a high byte and a mid-line marker.
      send_text("a ");
      send_word(8'hFF, 1'b0);
      send_text(">\n");
      // Marker at a sequence line start, then an empty record.
      send_text(">\n>");
      // End inside a record, then a second end.
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
   endtask

   task automatic test_mode_extremes();
      write_all_settings('0, '0, '0, '0, 2'd0, 1'b1, 1'b0);
      stall_style = STALL_NONE;
      send_stream(100, 5);
      write_all_settings('1, '1, '1, '1, 2'd2, 1'b0, 1'b1);
      stall_style = STALL_PATTERN;
      send_stream(100, 5);
      // Every character ignored: only counts move on sequence lines.
      write_all_settings({32{2'b01}}, {32{2'b01}}, {32{2'b01}}, {32{2'b01}},
                         2'd1, 1'b1, 1'b1);
      stall_style = STALL_RANDOM;
      send_stream(100, 5);
      write_all_settings({32{2'b10}}, {32{2'b10}}, {32{2'b10}}, {32{2'b10}},
                         2'd0, 1'b0, 1'b0);
      stall_style = STALL_PATTERN;
      send_stream(100, 5);
   endtask

   task automatic test_random_modes();
      repeat (4) begin
         write_all_settings({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
         stall_style = $urandom_range(STALL_NONE, STALL_PATTERN);
         send_stream(120, 5);
      end
   endtask

   // A long hold-off on the result side while sequence words keep coming,
   // then a pause until every result has arrived.
   task automatic test_backpressure();
      write_all_settings('0, '0, '0, '0, 2'd0, 1'b0, 1'b1);
      stall_style  = STALL_NONE;
      hold_pending = 1'b1;
      send_text(">stall\n");
      repeat (60) send_word(pick_sequence_char(), 1'b0);
      wait_for_idle();
      stall_style = STALL_RANDOM;
      send_stream(40, 5);
   endtask

   task automatic test_stream_noise();
      write_all_settings({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom},
                         2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
      stall_style = STALL_RANDOM;
      send_stream(120, 40);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_mode_extremes();
      test_random_modes();
      test_backpressure();
      test_stream_noise();
      wait_for_idle();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("%0t: run timed out", $time);
      $display("tb: failure");
      $finish;
   end

endmodule
